@@ hw/rtl/wps_pkg.sv @@
// Shared widths, constants and register indexes for the wheel speed block.
`timescale 1ns / 1ps
package wps_pkg;

    localparam int TIME_W   = 32;
    localparam int SPEED_W  = 9;
    localparam int AGE_W    = 8;
    localparam int CIRC_W   = 10;
    localparam int COUNT_W  = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 10;

    // circumference * 72 * pulse count fits in 22 bits
    localparam int PROD_W   = 22;
    // rounded speed stays below 2^13 for any gap above the compute gap
    localparam int QUO_W    = 13;

    localparam int unsigned COMPUTE_GAP_MS = 250;
    localparam int unsigned DEBOUNCE_MS    = 15;
    localparam int unsigned SPEED_LIMIT    = 350;
    localparam int unsigned FRESH_MS       = 1000;
    localparam int unsigned MAX_FIX_AGE    = 2;
    localparam int unsigned COUNT_MAX      = 31;

    localparam logic [CFG_IDX_W-1:0] REG_CIRC     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAKEOVER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GPS_ONLY = 2'd2;

    localparam logic OP_PULSE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

endpackage

@@ hw/rtl/wps_if.sv @@
// Valid/ready channel interfaces for input items and results.
`timescale 1ns / 1ps
interface wps_in_if import wps_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               op;
    logic [TIME_W-1:0]  time_ms;
    logic [SPEED_W-1:0] gps_kmh;
    logic [AGE_W-1:0]   gps_fix_age;
    logic               gps_moving;

    modport source (output valid, op, time_ms, gps_kmh, gps_fix_age, gps_moving,
                    input ready);
    modport sink   (input valid, op, time_ms, gps_kmh, gps_fix_age, gps_moving,
                    output ready);
endinterface

interface wps_out_if import wps_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [SPEED_W-1:0] speed_kmh;
    logic               reed_error;

    modport source (output valid, speed_kmh, reed_error, input ready);
    modport sink   (input valid, speed_kmh, reed_error, output ready);
endinterface

@@ hw/rtl/wps_div.sv @@
// Serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module wps_div #(
    parameter int N_W = 33,
    parameter int D_W = 33,
    parameter int Q_W = 13
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] num,
    input  logic [D_W-1:0] den,
    output logic           done,
    output logic [Q_W-1:0] quo
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic [D_W-1:0]   rem_reg, rem_next;
    logic [D_W-1:0]   den_reg, den_next;
    logic [Q_W-1:0]   sh_reg, sh_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [D_W:0]     trial;
    logic             ge;

    assign trial = {rem_reg, sh_reg[Q_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        sh_next   = sh_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            // upper dividend bits are already below the divisor
            rem_next  = D_W'(num >> Q_W);
            sh_next   = num[Q_W-1:0];
            den_next  = den;
            cnt_next  = CNT_W'(Q_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? D_W'(trial - {1'b0, den_reg}) : trial[D_W-1:0];
            sh_next  = {sh_reg[Q_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        sh_reg  <= sh_next;
    end

    assign done = done_reg;
    assign quo  = sh_reg;

endmodule

@@ hw/rtl/wheel_pulse_speed_with_gps_fallback.sv @@
// Top level: reed pulse speed computation with GPS fallback on queries.
//
//  channel  | dir | beat contents
//  ---------+-----+---------------------------------------------------
//  req      | in  | op, time_ms, gps_kmh, gps_fix_age, gps_moving
//  rsp      | out | speed_kmh, reed_error
//  cfg_*    | in  | cfg_index, cfg_data written when cfg_we is high
//
// Queries and pulses that do not compute: result registered in res_*, then
// moved to the output register once free. Computing pulses first run the
// serial divider, one quotient bit per cycle. One item in flight at a time;
// a new item is taken once the previous result sits in the output register.
// rsp stalls hold results; reset clears all but data regs; no clearing pass.
`timescale 1ns / 1ps
module wheel_pulse_speed_with_gps_fallback import wps_pkg::*; #(
    parameter int TIME_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    wps_in_if.sink                req,
    wps_out_if.source             rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int TB  = TIME_BITS;
    localparam int N_W = ((PROD_W > TB) ? PROD_W : TB) + 1;
    localparam int D_W = TB + 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_WAIT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [CIRC_W-1:0]  circ_reg;
    logic [SPEED_W-1:0] takeover_reg;
    logic               gps_only_reg;

    logic [TB-1:0]      last_comp_reg, last_comp_next;
    logic [TB-1:0]      last_cnt_reg, last_cnt_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [SPEED_W-1:0] reed_reg, reed_next;
    logic               err_reg, err_next;

    logic [SPEED_W-1:0] res_speed_reg, res_speed_next;
    logic               res_err_reg, res_err_next;
    logic               out_valid_reg, out_valid_next;
    logic [SPEED_W-1:0] out_speed_reg, out_speed_next;
    logic               out_err_reg, out_err_next;

    logic [TB-1:0]      now;
    logic [TB-1:0]      d_comp;
    logic [TB-1:0]      d_cnt;
    logic               accept;
    logic               out_free;
    logic [CIRC_W+COUNT_W-1:0] circ_count;
    logic [PROD_W-1:0]  prod;
    logic [N_W-1:0]     div_num;
    logic [D_W-1:0]     div_den;
    logic               div_start;
    logic               div_done;
    logic [QUO_W-1:0]   div_quo;
    logic [SPEED_W-1:0] diff;
    logic               take_gps;

    assign now      = req.time_ms[TB-1:0];
    assign d_comp   = now - last_comp_reg;
    assign d_cnt    = now - last_cnt_reg;
    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE);

    // circumference * 36 * count * 2 = cc * 64 + cc * 8
    assign circ_count = circ_reg * count_reg;
    assign prod = PROD_W'({circ_count, 6'b0}) + PROD_W'({circ_count, 3'b0});
    assign div_num = N_W'(prod) + N_W'(d_comp);
    assign div_den = {d_comp, 1'b0};
    assign div_start = accept && (req.op == OP_PULSE) && (d_comp > TB'(COMPUTE_GAP_MS));

    assign diff = (reed_reg > req.gps_kmh) ? reed_reg - req.gps_kmh
                                           : req.gps_kmh - reed_reg;
    assign take_gps = (reed_reg > takeover_reg) && (req.gps_kmh > takeover_reg) &&
                      (req.gps_fix_age <= AGE_W'(MAX_FIX_AGE)) && (diff < (reed_reg >> 3));

    wps_div #(
        .N_W (N_W),
        .D_W (D_W),
        .Q_W (QUO_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        state_next     = state_reg;
        last_comp_next = last_comp_reg;
        last_cnt_next  = last_cnt_reg;
        count_next     = count_reg;
        reed_next      = reed_reg;
        err_next       = err_reg;
        res_speed_next = res_speed_reg;
        res_err_next   = res_err_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_speed_next = out_speed_reg;
        out_err_next   = out_err_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_WAIT;
                    if (req.op == OP_PULSE)
                    begin
                        err_next     = 1'b0;
                        res_err_next = 1'b0;
                        res_speed_next = reed_reg;
                        if (div_start)
                        begin
                            state_next     = ST_DIV;
                            last_comp_next = now;
                            last_cnt_next  = now;
                            count_next     = COUNT_W'(1);
                        end
                        else if (d_cnt > TB'(DEBOUNCE_MS))
                        begin
                            if (count_reg < COUNT_W'(COUNT_MAX))
                                count_next = count_reg + 1'b1;
                            last_cnt_next = now;
                        end
                    end
                    else if (gps_only_reg)
                    begin
                        res_speed_next = req.gps_kmh;
                        res_err_next   = err_reg;
                    end
                    else if (d_comp < TB'(FRESH_MS))
                    begin
                        res_speed_next = take_gps ? req.gps_kmh : reed_reg;
                        res_err_next   = err_reg;
                    end
                    else if (req.gps_moving)
                    begin
                        err_next       = 1'b1;
                        res_speed_next = req.gps_kmh;
                        res_err_next   = 1'b1;
                    end
                    else
                    begin
                        err_next       = 1'b0;
                        reed_next      = '0;
                        res_speed_next = '0;
                        res_err_next   = 1'b0;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_WAIT;
                    if (div_quo < QUO_W'(SPEED_LIMIT))
                    begin
                        reed_next      = div_quo[SPEED_W-1:0];
                        res_speed_next = div_quo[SPEED_W-1:0];
                    end
                end
            end
            ST_WAIT:
            begin
                if (out_free)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    out_speed_next = res_speed_reg;
                    out_err_next   = res_err_reg;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            circ_reg      <= '0;
            takeover_reg  <= '0;
            gps_only_reg  <= 1'b0;
            last_comp_reg <= '0;
            last_cnt_reg  <= '0;
            count_reg     <= '0;
            reed_reg      <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_comp_reg <= last_comp_next;
            last_cnt_reg  <= last_cnt_next;
            count_reg     <= count_next;
            reed_reg      <= reed_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CIRC:     circ_reg     <= cfg_data[CIRC_W-1:0];
                    REG_TAKEOVER: takeover_reg <= cfg_data[SPEED_W-1:0];
                    REG_GPS_ONLY: gps_only_reg <= cfg_data[0];
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_speed_reg <= res_speed_next;
        res_err_reg   <= res_err_next;
        out_speed_reg <= out_speed_next;
        out_err_reg   <= out_err_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.speed_kmh  = out_speed_reg;
    assign rsp.reed_error = out_err_reg;

endmodule

@@ hw/rtl/wps_checker.sv @@
// Port-level assertions for the wheel speed block, with its bind.
`timescale 1ns / 1ps
module wps_checker import wps_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [SPEED_W-1:0] out_speed,
    input logic               out_err
);

    // one item in flight: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while previous item still in flight");

    // result is never presented in the cycle right after acceptance
    a_no_same_cycle_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !out_valid) |=> !out_valid)
        else $error("result appeared before processing completed");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");

    a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(out_speed) && $stable(out_err)))
        else $error("result payload changed while stalled");

endmodule

bind wheel_pulse_speed_with_gps_fallback wps_checker u_wps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_speed (rsp.speed_kmh),
    .out_err   (rsp.reed_error)
);
